// ----- hw/rtl/pps_pkg.sv -----
`default_nettype none
package pps_pkg;

  // Storage between the classifying front and the entry-building back
  localparam int unsigned QueueDepth = 2;

  localparam logic [11:0] OFFSET_MAX = 12'hFFF;
  localparam logic [11:0] PAT_FIRST  = 12'd8;
  localparam logic [12:0] PMT_FIRST  = 13'd12;
  localparam logic [12:0] PID_SKIP   = 13'h0010;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0F;
  localparam logic [7:0]  PID_HI_MASK = 8'h1F;

  localparam logic ENTRY_PAT = 1'b0;
  localparam logic ENTRY_PMT = 1'b1;

  // Work handed from front to back
  typedef enum logic [1:0] {
    OP_START,
    OP_PAT,
    OP_PMT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } work_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] number_or_type;
    logic [12:0] pid;
  } entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pps_queue.sv -----
`default_nettype none
module pps_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push_valid,
  input  wire pps_pkg::work_t push_item,
  output logic                push_ready,
  output logic                pop_valid,
  input  wire                 pop_ready,
  output pps_pkg::work_t      pop_item
);
  import pps_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  work_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntFull);
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pps_front.sv -----
`default_nettype none
module pps_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_byte,
  input  wire                 in_start,
  input  wire                 q_ready,
  output logic                push_valid,
  output pps_pkg::work_t      push_item
);
  import pps_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PAT  = 2'd1;
  localparam logic [1:0] KIND_PMT  = 2'd2;

  logic [11:0] byte_offset;
  logic [1:0]  table_kind;
  logic [11:0] section_length;
  logic [11:0] entry_start;
  logic [3:0]  info_hi;

  logic        accept;
  logic [11:0] off_next;
  logic [12:0] pmt_first;
  logic [11:0] first_sat;
  logic        before_crc;
  logic        is_len_hi;
  logic        is_len_lo;
  logic        is_info_hi;
  logic        is_info_lo;
  logic        in_entries;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  always_comb begin
    off_next   = (byte_offset != OFFSET_MAX) ? byte_offset + 12'd1 : byte_offset;
    pmt_first  = PMT_FIRST + {1'b0, info_hi, in_byte};
    first_sat  = pmt_first[12] ? OFFSET_MAX : pmt_first[11:0];
    before_crc = ({1'b0, off_next} + 13'd1) < {1'b0, section_length};
    is_len_hi  = (off_next == 12'd1);
    is_len_lo  = (off_next == 12'd2);
    is_info_hi = (table_kind == KIND_PMT) && (off_next == 12'd10);
    is_info_lo = (table_kind == KIND_PMT) && (off_next == 12'd11);
    in_entries = (table_kind != KIND_NONE) && !is_len_hi && !is_len_lo
                 && !is_info_hi && !is_info_lo
                 && (off_next >= entry_start) && before_crc;
  end

  always_comb begin
    push_valid     = accept && (in_start || in_entries);
    push_item.data = in_byte;
    if (in_start) begin
      push_item.op = OP_START;
    end else if (table_kind == KIND_PMT) begin
      push_item.op = OP_PMT;
    end else begin
      push_item.op = OP_PAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      table_kind     <= KIND_NONE;
      section_length <= '0;
      entry_start    <= '0;
      info_hi        <= '0;
    end else if (accept) begin
      if (in_start) begin
        byte_offset    <= '0;
        section_length <= '0;
        info_hi        <= '0;
        if (in_byte == 8'h00) begin
          table_kind  <= KIND_PAT;
          entry_start <= PAT_FIRST;
        end else if (in_byte == 8'h02) begin
          table_kind  <= KIND_PMT;
          entry_start <= OFFSET_MAX;
        end else begin
          table_kind  <= KIND_NONE;
          entry_start <= OFFSET_MAX;
        end
      end else if (table_kind != KIND_NONE) begin
        byte_offset <= off_next;
        if (is_len_hi) begin
          section_length <= {in_byte[3:0] & NIBBLE_MASK[3:0], 8'h00};
        end else if (is_len_lo) begin
          section_length <= {section_length[11:8], in_byte};
        end else if (is_info_hi) begin
          info_hi <= in_byte[3:0] & NIBBLE_MASK[3:0];
        end else if (is_info_lo) begin
          entry_start <= first_sat;
          info_hi     <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pps_back.sv -----
`default_nettype none
module pps_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  wire pps_pkg::work_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output pps_pkg::entry_t     out_entry
);
  import pps_pkg::*;

  logic [2:0]  entry_byte_index;
  logic [11:0] skip_remaining;
  logic [15:0] entry_bytes;
  logic [12:0] pid_hold;

  logic [2:0]  index_next;
  logic [11:0] skip_next;
  logic [15:0] bytes_next;
  logic [12:0] pid_next;
  logic [12:0] pid_full;
  logic [12:0] pid_top;
  logic        emit;

  // Take work only when the result register is free or draining
  assign q_pop    = q_valid && (!out_valid || out_ready);
  assign pid_full = {pid_hold[12:8], q_item.data};
  assign pid_top  = {q_item.data[4:0] & PID_HI_MASK[4:0], 8'h00};

  always_comb begin
    index_next = entry_byte_index;
    skip_next  = skip_remaining;
    bytes_next = entry_bytes;
    pid_next   = pid_hold;
    emit       = 1'b0;
    if (q_pop) begin
      case (q_item.op)
        OP_START: begin
          index_next = '0;
          skip_next  = '0;
          bytes_next = '0;
          pid_next   = '0;
        end
        OP_PAT: begin
          if (skip_remaining != '0) begin
            skip_next = skip_remaining - 12'd1;
          end else begin
            case (entry_byte_index)
              3'd0: begin
                bytes_next = {q_item.data, 8'h00};
                index_next = 3'd1;
              end
              3'd1: begin
                bytes_next = {entry_bytes[15:8], q_item.data};
                index_next = 3'd2;
              end
              3'd2: begin
                pid_next   = pid_top;
                index_next = 3'd3;
              end
              default: begin
                pid_next   = pid_full;
                index_next = 3'd0;
                emit       = (pid_full != PID_SKIP);
              end
            endcase
          end
        end
        OP_PMT: begin
          if (skip_remaining != '0) begin
            skip_next = skip_remaining - 12'd1;
          end else begin
            case (entry_byte_index)
              3'd0: begin
                bytes_next = {8'h00, q_item.data};
                index_next = 3'd1;
              end
              3'd1: begin
                pid_next   = pid_top;
                index_next = 3'd2;
              end
              3'd2: begin
                pid_next   = pid_full;
                index_next = 3'd3;
              end
              3'd3: begin
                skip_next  = {q_item.data[3:0] & NIBBLE_MASK[3:0], 8'h00};
                index_next = 3'd4;
              end
              default: begin
                skip_next  = {skip_remaining[11:8], q_item.data};
                index_next = 3'd0;
                emit       = 1'b1;
              end
            endcase
          end
        end
        default: begin
          index_next = entry_byte_index;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_byte_index <= '0;
      skip_remaining   <= '0;
      entry_bytes      <= '0;
      pid_hold         <= '0;
      out_valid        <= 1'b0;
    end else begin
      entry_byte_index <= index_next;
      skip_remaining   <= skip_next;
      entry_bytes      <= bytes_next;
      pid_hold         <= pid_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A stream entry ends on the ES-info length, so its PID is already complete
  always_ff @(posedge clk) begin
    if (emit) begin
      out_entry.kind           <= (q_item.op == OP_PMT) ? ENTRY_PMT : ENTRY_PAT;
      out_entry.number_or_type <= entry_bytes;
      out_entry.pid            <= (q_item.op == OP_PMT) ? pid_hold : pid_full;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/psi_pat_pmt_section_parser.sv -----
`default_nettype none
// PSI section parser for PAT and PMT tables. Feed a section one byte per item
// on s_*, with s_tuser high on the table id byte; table id 0 is parsed as a
// PAT (one item per program entry, entries with PID 0x10 dropped), table id 2
// as a PMT (one item per elementary stream, descriptors skipped), and any
// other table is ignored up to the next start byte. Entries end before the
// four CRC bytes and a partial entry there is dropped. The block takes one
// byte every clock, and s_tready falls only once the queue is full behind a
// held result. The front keeps the section offset, length and entry start
// and classifies each byte, a queue of QUEUE_DEPTH items decouples it from
// the back, which assembles entries into a registered output. An entry's
// last byte passes the queue, then the output register, to m_tvalid.
module psi_pat_pmt_section_parser #(
  parameter int unsigned QUEUE_DEPTH = pps_pkg::QueueDepth
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] section_byte
  input  wire         s_tuser,   // [0] section_start
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [15:0] number_or_type, [28:16] entry_pid, [31:29] zero
  output logic        m_tuser    // [0] entry_kind
);
  import pps_pkg::*;

  logic   push_valid;
  logic   push_ready;
  work_t  push_item;
  logic   pop_valid;
  logic   pop_ready;
  work_t  pop_item;
  entry_t entry;

  // Front: track offsets and length, pass on start and entry bytes only
  pps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_start   (s_tuser),
    .q_ready    (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  pps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: gather entry fields, skip ES info, hold the finished entry
  pps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_item    (pop_item),
    .q_pop     (pop_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_entry (entry)
  );

  assign m_tdata = {3'b000, entry.pid, entry.number_or_type};
  assign m_tuser = entry.kind;

  // A PAT entry carrying the network PID never leaves the block
  a_pat_skip: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ENTRY_PAT) |-> (m_tdata[28:16] != PID_SKIP))
    else $error("PAT entry with skipped PID emitted");

  // Stream type is a single byte
  a_pmt_type: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ENTRY_PMT) |-> (m_tdata[15:8] == 8'h00))
    else $error("PMT stream type wider than a byte");

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // Nothing is pushed into a full queue
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("push into full queue");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
  import pps_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RANDOM_ITEMS = 1850;
  localparam int LONG_PAT_ENTRIES = 120;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_SPACING = 2500;
  localparam longint WATCHDOG_TIME = 64'd10_000_000;
  localparam logic [7:0] TID_PAT = 8'h00;
  localparam logic [7:0] TID_PMT = 8'h02;

  typedef enum logic [1:0] {
    TBL_NONE,
    TBL_PAT,
    TBL_PMT
  } table_t;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       pinned;
    logic       emits;
    entry_t     want;
  } stim_row_t;

  localparam entry_t NO_ENTRY = '0;
  localparam int DIR_ROWS = 30;

  // Pinned rows carry their expected entry; the rest go through the parser model
  localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{1'b0, 8'hA5, 1'b1, 1'b0, NO_ENTRY},  // stray item before any section: ignored
    // PAT, section length 13, one entry at the extremes
    '{1'b1, TID_PAT, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hF0, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h0D, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hC1, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hFF, 1'b1, 1'b1, '{ENTRY_PAT, 16'hFFFF, 13'h1FFF}},
    // PMT, section length 18, no program info, one stream; CRC cut off by the
    // random part's first start
    '{1'b1, TID_PMT, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hB0, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h12, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hC1, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hE1, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hF0, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'hF0, 1'b0, 1'b0, NO_ENTRY},
    '{1'b0, 8'h00, 1'b1, 1'b1, '{ENTRY_PMT, 16'h00FF, 13'h1FFF}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  entry_t     expected_entries[$];
  entry_t     head_entry;
  logic [8:0] frame[$];   // {section_start, section_byte}
  logic       steady_send = 1'b0;
  int         faults = 0;

  // Parser model state
  logic [11:0] sec_offset;
  logic [11:0] sec_len;
  logic [11:0] first_entry;
  logic [11:0] es_skip;
  table_t      sec_table;
  logic [15:0] gathered_num;
  logic [12:0] gathered_pid;
  logic [2:0]  entry_pos;

  psi_pat_pmt_section_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  task automatic clear_parser();
    sec_offset   = '0;
    sec_len      = '0;
    first_entry  = '0;
    es_skip      = '0;
    sec_table    = TBL_NONE;
    gathered_num = '0;
    gathered_pid = '0;
    entry_pos    = '0;
  endtask

  // Advance the parser model by one section byte; flag an entry when one completes
  task automatic parse_section_byte(input logic st, input logic [7:0] b,
                                    output logic emits, output entry_t ent);
    logic [12:0] loop_start;
    emits = 1'b0;
    ent = '0;
    if (st) begin
      clear_parser();
      sec_table = (b == TID_PAT) ? TBL_PAT : (b == TID_PMT) ? TBL_PMT : TBL_NONE;
      first_entry = (sec_table == TBL_PAT) ? PAT_FIRST : OFFSET_MAX;
    end else if (sec_table != TBL_NONE) begin
      if (sec_offset != OFFSET_MAX) sec_offset = sec_offset + 12'd1;
      if (sec_offset == 12'd1) begin
        sec_len = {b[3:0], 8'h00};
      end else if (sec_offset == 12'd2) begin
        sec_len[7:0] = b;
      end else if (sec_table == TBL_PMT && sec_offset == 12'd10) begin
        gathered_pid = {9'd0, b[3:0]};
      end else if (sec_table == TBL_PMT && sec_offset == 12'd11) begin
        // stream loop starts after the program info; clamp at the offset ceiling
        loop_start = PMT_FIRST + {1'b0, gathered_pid[3:0], b};
        first_entry = (loop_start > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : loop_start[11:0];
        gathered_pid = '0;
      end else if (sec_offset >= first_entry &&
                   {1'b0, sec_offset} + 13'd1 < {1'b0, sec_len}) begin
        if (es_skip != '0) begin
          es_skip = es_skip - 12'd1;
        end else if (sec_table == TBL_PAT) begin
          case (entry_pos)
            3'd0: begin
              gathered_num = {b, 8'h00};
              entry_pos = 3'd1;
            end
            3'd1: begin
              gathered_num[7:0] = b;
              entry_pos = 3'd2;
            end
            3'd2: begin
              gathered_pid = {b[4:0], 8'h00};
              entry_pos = 3'd3;
            end
            default: begin
              gathered_pid[7:0] = b;
              entry_pos = 3'd0;
              if (gathered_pid != PID_SKIP) begin
                emits = 1'b1;
                ent = '{ENTRY_PAT, gathered_num, gathered_pid};
              end
            end
          endcase
        end else begin
          case (entry_pos)
            3'd0: begin
              gathered_num = {8'h00, b};
              entry_pos = 3'd1;
            end
            3'd1: begin
              gathered_pid = {b[4:0], 8'h00};
              entry_pos = 3'd2;
            end
            3'd2: begin
              gathered_pid[7:0] = b;
              entry_pos = 3'd3;
            end
            3'd3: begin
              es_skip = {b[3:0], 8'h00};
              entry_pos = 3'd4;
            end
            default: begin
              es_skip[7:0] = b;
              entry_pos = 3'd0;
              emits = 1'b1;
              ent = '{ENTRY_PMT, gathered_num, gathered_pid};
            end
          endcase
        end
      end
    end
  endtask

  // Mostly back-to-back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(4, 24);
  endfunction

  task automatic push_bytes(input int n);
    repeat (n) frame.push_back({1'b0, 8'($urandom)});
  endtask

  // PAT with n entries; length bytes are patched by the caller
  task automatic build_pat(input int n);
    logic [12:0] pid;
    frame.push_back({1'b1, TID_PAT});
    push_bytes(7);
    repeat (n) begin
      pid = ($urandom_range(0, 4) == 0) ? PID_SKIP : 13'($urandom);
      push_bytes(2);
      frame.push_back({1'b0, 3'($urandom), pid[12:8]});
      frame.push_back({1'b0, pid[7:0]});
    end
    push_bytes(4);
  endtask

  // Offer one item, wait for the handshake, then predict
  task automatic send_item(input logic st, input logic [7:0] b, input logic pinned,
                           input logic pin_emits, input entry_t pin_want);
    int gap;
    logic emits;
    entry_t ent;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= st;
    do @(posedge clk); while (!s_tready);
    parse_section_byte(st, b, emits, ent);
    if (pinned) begin
      emits = pin_emits;
      ent = pin_want;
    end
    if (emits) expected_entries.push_back(ent);
  endtask

  initial begin
    int sent;
    int sec_l;
    int kind_pick;
    int d;
    int fill;
    int es;
    int cut;
    logic [7:0] tid;
    logic long_done;
    sent = 0;
    long_done = 1'b0;
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].pinned,
                DIRECTED_ROWS[i].emits, DIRECTED_ROWS[i].want);

    while (sent < RANDOM_ITEMS) begin
      frame.delete();
      if (!long_done && sent >= RANDOM_ITEMS / 2) begin
        // one long PAT that declares the largest section length
        build_pat(LONG_PAT_ENTRIES);
        frame[1] = {1'b0, 8'hBF};
        frame[2] = {1'b0, 8'hFF};
        long_done = 1'b1;
      end else begin
        kind_pick = $urandom_range(0, 99);
        if (kind_pick < 84) begin
          if (kind_pick < 42) begin
            build_pat($urandom_range(0, 5));
          end else begin
            frame.push_back({1'b1, TID_PMT});
            push_bytes(9);
            d = $urandom_range(0, 5);
            fill = d;
            if ($urandom_range(0, 19) == 0) begin
              // program info long enough to push the stream loop off the end
              d = $urandom_range(4084, 4095);
              fill = $urandom_range(0, 4);
            end
            frame.push_back({1'b0, 4'($urandom), d[11:8]});
            frame.push_back({1'b0, d[7:0]});
            push_bytes(fill);
            repeat ($urandom_range(0, 4)) begin
              es = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
              push_bytes(3);
              frame.push_back({1'b0, 4'($urandom), es[11:8]});
              frame.push_back({1'b0, es[7:0]});
              push_bytes(es);
            end
            push_bytes(4);
          end
          sec_l = frame.size() - 3;
          case ($urandom_range(0, 19))
            0: sec_l = $urandom_range(0, 1);
            1: sec_l = $urandom_range(0, 4095);
            default: ;
          endcase
          frame[1] = {1'b0, 4'($urandom), sec_l[11:8]};
          frame[2] = {1'b0, sec_l[7:0]};
          // abandon some sections early, overrun others
          if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, frame.size() - 1);
            while (frame.size() > cut) frame.delete(frame.size() - 1);
          end
          if ($urandom_range(0, 9) == 0) push_bytes($urandom_range(1, 6));
        end else if (kind_pick < 92) begin
          tid = ($urandom_range(0, 1) == 0) ? 8'h01 : 8'($urandom_range(3, 255));
          frame.push_back({1'b1, tid});
          push_bytes($urandom_range(0, 20));
        end else begin
          repeat ($urandom_range(1, 16))
            frame.push_back({($urandom_range(0, 7) == 0), 8'($urandom)});
        end
      end
      sent += frame.size();
      steady_send = ($urandom_range(0, 3) == 0);
      foreach (frame[i]) send_item(frame[i][8], frame[i][7:0], 1'b0, 1'b0, NO_ENTRY);
    end
    s_tvalid <= 1'b0;

    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0 && expected_entries.size() == 0) begin
      $display("psi_pat_pmt_section_parser verification clean");
    end else begin
      $display("psi_pat_pmt_section_parser verification failed");
    end
    $finish;
  end

  // Receiver: random back-pressure, steady stretches, and two long hold-offs
  initial begin
    int idle;
    int busy;
    int rx_cycles;
    int holds_done;
    rx_cycles = 0;
    holds_done = 0;
    forever begin
      if (holds_done < 2 && rx_cycles >= (holds_done + 1) * HOLD_SPACING) begin
        idle = HOLD_CYCLES;
        holds_done++;
      end else begin
        idle = pick_gap();
      end
      if (idle > 0) begin
        m_tready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      m_tready <= 1'b1;
      busy = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 6);
      repeat (busy) @(posedge clk);
      rx_cycles += idle + busy;
    end
  end

  // Compare each delivered entry against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_entries.size() == 0) begin
        $display("%0t: entry with nothing pending: kind %0d number %h pid %h", $time,
                 m_tuser, m_tdata[15:0], m_tdata[28:16]);
        faults = faults + 1;
      end else begin
        head_entry = expected_entries.pop_front();
        if (m_tuser !== head_entry.kind) begin
          $display("%0t: entry_kind mismatch, expected %0d, got %0d", $time,
                   head_entry.kind, m_tuser);
          faults = faults + 1;
        end
        if (m_tdata[15:0] !== head_entry.number_or_type) begin
          $display("%0t: number_or_type mismatch, expected %h, got %h", $time,
                   head_entry.number_or_type, m_tdata[15:0]);
          faults = faults + 1;
        end
        if (m_tdata[28:16] !== head_entry.pid) begin
          $display("%0t: entry_pid mismatch, expected %h, got %h", $time,
                   head_entry.pid, m_tdata[28:16]);
          faults = faults + 1;
        end
      end
    end
  end

  initial begin
    #(WATCHDOG_TIME);
    $display("psi_pat_pmt_section_parser verification failed");
    $finish;
  end

endmodule
`default_nettype wire
